@@ design/cfp_pkg.sv @@
package cfp_pkg;

    // operation codes carried on s_tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // frame layout
    localparam int PREFIX_BYTES = 5;
    localparam int CRC_BYTES    = 2;
    localparam int OFF_ADDR     = 1;
    localparam int OFF_FUNC_LO  = 2;
    localparam int OFF_FUNC_HI  = 3;
    localparam int OFF_LEN      = 4;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  HDR_RESET = 8'h5A;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] crc_t;

    // advance the CRC by one byte, MSB first
    function automatic crc_t crc16_step(input crc_t crc_in, input byte_t data);
        crc_t c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ design/cfp_ram.sv @@
module cfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/crc16_frame_parser.sv @@
// A push is accepted only in idle; then a rescan of the receive store runs before the
// next transfer: a read and a check per skipped byte and, for a complete frame, a read
// and a CRC step per byte plus the length and CRC byte checks; bounded by the store.
// A take emits its results one at a time, each after a held payload memory read, and
// waits on a stalled output. Reset (aresetn low, synchronous) empties the store and
// the hold slot and restores the header byte to 0x5A; memory contents are not cleared.
module crc16_frame_parser
    import cfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64,
    parameter int RX_DEPTH    = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config: header_byte
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] address, [23:8] function_code,
                                   // [30:24] payload_length, [38:31] payload_byte
    output logic        m_tuser,   // [0] frame_valid
    output logic        m_tlast    // last
);

    localparam int PW = $clog2(RX_DEPTH);
    localparam int HW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [PW:0] DEPTH_W = (PW+1)'(RX_DEPTH);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FIND_RD  = 4'd1;
    localparam logic [3:0] S_FIND_CHK = 4'd2;
    localparam logic [3:0] S_LEN_RD   = 4'd3;
    localparam logic [3:0] S_LEN_CHK  = 4'd4;
    localparam logic [3:0] S_CRC_RD   = 4'd5;
    localparam logic [3:0] S_CRC_ACC  = 4'd6;
    localparam logic [3:0] S_HI_RD    = 4'd7;
    localparam logic [3:0] S_HI_CHK   = 4'd8;
    localparam logic [3:0] S_LO_RD    = 4'd9;
    localparam logic [3:0] S_LO_CHK   = 4'd10;
    localparam logic [3:0] S_TAKE_RD  = 4'd11;
    localparam logic [3:0] S_TAKE_OUT = 4'd12;

    logic [3:0]    state_reg, state_next;
    logic [7:0]    hdr_reg;
    logic [PW-1:0] head_reg, head_next;
    logic [PW:0]   fill_reg, fill_next;
    logic [PW:0]   off_reg, off_next;
    logic [7:0]    len_reg, len_next;
    crc_t          crc_reg, crc_next;
    logic [7:0]    crc_hi_reg, crc_hi_next;
    logic [7:0]    cap_addr_reg, cap_addr_next;
    logic [15:0]   cap_func_reg, cap_func_next;
    logic [7:0]    held_addr_reg, held_addr_next;
    logic [15:0]   held_func_reg, held_func_next;
    logic [6:0]    held_len_reg, held_len_next;
    logic          held_reg, held_next;
    logic [HW-1:0] k_reg, k_next;
    logic          mv_reg, mv_next;
    logic [39:0]   md_reg, md_next;
    logic          mu_reg, mu_next;
    logic          ml_reg, ml_next;

    logic [PW-1:0] st_wr_addr, st_rd_addr;
    logic          st_wr_en;
    logic [7:0]    st_rd_data;
    logic          hp_wr_en;
    logic [HW-1:0] hp_wr_addr;
    logic [7:0]    hp_rd_data;
    logic          out_free, take_last;
    logic [8:0]    total9;

    // store position of a logical offset from the head
    function automatic logic [PW-1:0] pos(input logic [PW-1:0] h, input logic [PW:0] o);
        logic [PW:0] s;
        s = {1'b0, h} + o;
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[PW-1:0];
    endfunction

    cfp_ram #(.WIDTH(8), .DEPTH(RX_DEPTH), .AW(PW)) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (s_tdata),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    cfp_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD), .AW(HW)) u_held (
        .aclk    (aclk),
        .wr_en   (hp_wr_en),
        .wr_addr (hp_wr_addr),
        .wr_data (st_rd_data),
        .rd_addr (k_reg),
        .rd_data (hp_rd_data)
    );

    // accept a header write only between scans
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = md_reg;
    assign m_tuser   = mu_reg;
    assign m_tlast   = ml_reg;

    assign out_free  = !mv_reg || m_tready;
    assign total9    = {1'b0, len_reg} + 9'(PREFIX_BYTES + CRC_BYTES);
    assign take_last = !held_reg || (held_len_reg == 7'd0)
                       || ({1'b0, k_reg} == (HW+1)'(held_len_reg - 7'd1));

    // store write address on push
    assign st_wr_en   = (state_reg == S_IDLE) && s_tvalid && (s_tuser == OP_PUSH);
    assign st_wr_addr = (fill_reg == DEPTH_W) ? head_reg : pos(head_reg, fill_reg);

    // held payload write during the CRC pass when the slot is free
    assign hp_wr_en   = (state_reg == S_CRC_ACC) && !held_reg
                        && (off_reg >= (PW+1)'(PREFIX_BYTES));
    assign hp_wr_addr = HW'(off_reg - (PW+1)'(PREFIX_BYTES));

    // store read address by state
    always_comb begin
        unique case (state_reg)
            S_LEN_RD: st_rd_addr = pos(head_reg, (PW+1)'(OFF_LEN));
            S_CRC_RD: st_rd_addr = pos(head_reg, off_reg);
            S_HI_RD:  st_rd_addr = pos(head_reg, (PW+1)'(total9 - 9'd2));
            S_LO_RD:  st_rd_addr = pos(head_reg, (PW+1)'(total9 - 9'd1));
            default:  st_rd_addr = head_reg;
        endcase
    end

    // scan and take sequencer
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        crc_hi_next    = crc_hi_reg;
        cap_addr_next  = cap_addr_reg;
        cap_func_next  = cap_func_reg;
        held_addr_next = held_addr_reg;
        held_func_next = held_func_reg;
        held_len_next  = held_len_reg;
        held_next      = held_reg;
        k_next         = k_reg;
        mv_next        = mv_reg && !m_tready;
        md_next        = md_reg;
        mu_next        = mu_reg;
        ml_next        = ml_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tuser == OP_PUSH) begin
                    fill_next  = (fill_reg == DEPTH_W) ? (PW+1)'(1) : fill_reg + 1'b1;
                    state_next = S_FIND_RD;
                end else if (s_tvalid) begin
                    k_next     = '0;
                    state_next = S_TAKE_RD;
                end
            end
            S_FIND_RD: begin
                state_next = (fill_reg == '0) ? S_IDLE : S_FIND_CHK;
            end
            S_FIND_CHK: begin
                if (st_rd_data == hdr_reg) begin
                    state_next = (fill_reg < (PW+1)'(PREFIX_BYTES)) ? S_IDLE : S_LEN_RD;
                end else begin
                    head_next  = pos(head_reg, (PW+1)'(1));
                    fill_next  = fill_reg - 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_LEN_RD: begin
                state_next = S_LEN_CHK;
            end
            S_LEN_CHK: begin
                len_next = st_rd_data;
                if (st_rd_data > 8'(MAX_PAYLOAD)) begin
                    head_next  = pos(head_reg, (PW+1)'(1));
                    fill_next  = fill_reg - 1'b1;
                    state_next = S_FIND_RD;
                end else if (9'(fill_reg) < {1'b0, st_rd_data} + 9'(PREFIX_BYTES + CRC_BYTES))
                begin
                    state_next = S_IDLE;
                end else begin
                    off_next   = '0;
                    crc_next   = '0;
                    state_next = S_CRC_RD;
                end
            end
            S_CRC_RD: begin
                state_next = S_CRC_ACC;
            end
            S_CRC_ACC: begin
                crc_next = crc16_step(crc_reg, st_rd_data);
                if (off_reg == (PW+1)'(OFF_ADDR)) begin
                    cap_addr_next = st_rd_data;
                end
                if (off_reg == (PW+1)'(OFF_FUNC_LO)) begin
                    cap_func_next[7:0] = st_rd_data;
                end
                if (off_reg == (PW+1)'(OFF_FUNC_HI)) begin
                    cap_func_next[15:8] = st_rd_data;
                end
                if (9'(off_reg) == total9 - 9'd3) begin
                    state_next = S_HI_RD;
                end else begin
                    off_next   = off_reg + 1'b1;
                    state_next = S_CRC_RD;
                end
            end
            S_HI_RD: begin
                state_next = S_HI_CHK;
            end
            S_HI_CHK: begin
                crc_hi_next = st_rd_data;
                state_next  = S_LO_RD;
            end
            S_LO_RD: begin
                state_next = S_LO_CHK;
            end
            S_LO_CHK: begin
                if ({crc_hi_reg, st_rd_data} == crc_reg) begin
                    if (!held_reg) begin
                        held_addr_next = cap_addr_reg;
                        held_func_next = cap_func_reg;
                        held_len_next  = len_reg[6:0];
                        held_next      = 1'b1;
                    end
                    head_next = pos(head_reg, (PW+1)'(total9));
                    fill_next = fill_reg - (PW+1)'(total9);
                end else begin
                    head_next = pos(head_reg, (PW+1)'(1));
                    fill_next = fill_reg - 1'b1;
                end
                state_next = S_FIND_RD;
            end
            S_TAKE_RD: begin
                state_next = S_TAKE_OUT;
            end
            S_TAKE_OUT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    mu_next = held_reg;
                    ml_next = take_last;
                    md_next = '0;
                    if (held_reg) begin
                        md_next[7:0]   = held_addr_reg;
                        md_next[23:8]  = held_func_reg;
                        md_next[30:24] = held_len_reg;
                        md_next[38:31] = (held_len_reg == 7'd0) ? 8'd0 : hp_rd_data;
                    end
                    if (take_last) begin
                        held_next  = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_TAKE_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold control state, reset on aresetn
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            hdr_reg       <= HDR_RESET;
            head_reg      <= '0;
            fill_reg      <= '0;
            held_reg      <= 1'b0;
            held_addr_reg <= '0;
            held_func_reg <= '0;
            held_len_reg  <= '0;
            mv_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            held_reg      <= held_next;
            held_addr_reg <= held_addr_next;
            held_func_reg <= held_func_next;
            held_len_reg  <= held_len_next;
            mv_reg        <= mv_next;
            if (cfg_valid && cfg_ready) begin
                hdr_reg <= cfg_data;
            end
        end
    end

    // advance payload registers
    always_ff @(posedge aclk) begin
        off_reg      <= off_next;
        len_reg      <= len_next;
        crc_reg      <= crc_next;
        crc_hi_reg   <= crc_hi_next;
        cap_addr_reg <= cap_addr_next;
        cap_func_reg <= cap_func_next;
        k_reg        <= k_next;
        md_reg       <= md_next;
        mu_reg       <= mu_next;
        ml_reg       <= ml_next;
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_W)
        else $error("receive fill count above store depth");

    a_held_write: assert property (@(posedge aclk) disable iff (!aresetn)
        hp_wr_en |-> !held_reg && state_reg == S_CRC_ACC)
        else $error("held payload written while slot is occupied");

    a_take_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TAKE_OUT && out_free && take_last) |=> !held_reg && m_tvalid && m_tlast)
        else $error("take did not empty the slot on its last result");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CRC_ACC) |=> !s_tready)
        else $error("input accepted during CRC pass");

endmodule
